/* rtl/core/hsva_pkg.sv */
// ----------------------------------------------------------------------------
// HSV adjust package
// Shared widths, fixed-point constants, register indexes and helpers for the
// hue / saturation / value adjustment pipeline.
// ----------------------------------------------------------------------------
package hsva_pkg;

  // Channel width and packed stream width (four channels, padded to bytes).
  localparam int CHANNEL_BITS = 16;
  localparam int TDATA_W      = ((4 * CHANNEL_BITS + 7) / 8) * 8;

  // Hue and saturation are fractions with 24 fraction bits; one is 2^24.
  localparam int HUE_FRAC = 24;
  localparam int UNIT_W   = HUE_FRAC + 1;
  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << HUE_FRAC;

  // Divider geometry: dividend below twice the divisor, 25 quotient bits.
  localparam int DIV_W      = CHANNEL_BITS + 3;
  localparam int QUO_W      = HUE_FRAC + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  // Pipeline register positions in the sideband shift line.
  localparam int IX_DIV_OUT = 1 + DIV_STAGES;
  localparam int IX_ADJ     = IX_DIV_OUT + 1;
  localparam int IX_HUE     = IX_ADJ + 1;
  localparam int IX_LANE    = IX_HUE + 2;
  localparam int IX_MIX     = IX_LANE + 1;
  localparam int IX_OUT     = IX_MIX + 1;
  localparam int PIPE_DEPTH = IX_OUT + 1;

  // Configuration registers.
  localparam int GAIN_W     = 17;
  localparam int CFG_ADDR_W = 8;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] MIX_ONE    = GAIN_W'(65536);
  localparam logic [CFG_ADDR_W-1:0] CFG_HUE_SHIFT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_SAT_GAIN   = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_VAL_GAIN   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_MIX_FACTOR = CFG_ADDR_W'(3);

  // Width of the signed hue-ramp arithmetic (covers 6 * hue and offsets).
  localparam int RAMP_W = HUE_FRAC + 5;

  // Clamp a signed ramp value to the range 0..one.
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [RAMP_W-1:0] x);
    logic [UNIT_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed({4'b0, UNIT_ONE})) begin
      res = UNIT_ONE;
    end else begin
      res = x[UNIT_W-1:0];
    end
    return res;
  endfunction

  // Absolute value of a signed ramp value.
  function automatic logic signed [RAMP_W-1:0] abs_ramp(input logic signed [RAMP_W-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

endpackage

/* rtl/core/hsva_div.sv */
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Computes floor(num * 2^24 / den) for num < 2 * den, a few quotient bits per
// register stage, restoring style.
// ----------------------------------------------------------------------------
module hsva_div (
  input  logic                            clk,
  input  logic                            ce,
  input  logic [hsva_pkg::DIV_W-1:0]      num,
  input  logic [hsva_pkg::DIV_W-1:0]      den,
  output logic [hsva_pkg::QUO_W-1:0]      quo
);

  logic [hsva_pkg::DIV_W:0]   rem_q [hsva_pkg::DIV_STAGES];
  logic [hsva_pkg::DIV_W-1:0] den_q [hsva_pkg::DIV_STAGES];
  logic [hsva_pkg::QUO_W-1:0] quo_q [hsva_pkg::DIV_STAGES];

  for (genvar st = 0; st < hsva_pkg::DIV_STAGES; st++) begin : g_stage
    logic [hsva_pkg::DIV_W:0]   rem_in;
    logic [hsva_pkg::DIV_W-1:0] den_in;
    logic [hsva_pkg::QUO_W-1:0] quo_in;
    logic [hsva_pkg::DIV_W:0]   rem_c;
    logic [hsva_pkg::QUO_W-1:0] quo_c;

    // Stage input: the operands for the first stage, else the previous stage.
    if (st == 0) begin : g_first
      assign rem_in = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[st-1];
      assign den_in = den_q[st-1];
      assign quo_in = quo_q[st-1];
    end

    // A few compare-and-subtract steps; the first step of all has no doubling.
    always_comb begin
      rem_c = rem_in;
      quo_c = quo_in;
      for (int j = 0; j < hsva_pkg::DIV_STEPS; j++) begin
        if (st * hsva_pkg::DIV_STEPS + j < hsva_pkg::QUO_W) begin
          if (st * hsva_pkg::DIV_STEPS + j != 0) begin
            rem_c = {rem_c[hsva_pkg::DIV_W-1:0], 1'b0};
          end
          if (rem_c >= {1'b0, den_in}) begin
            rem_c = rem_c - {1'b0, den_in};
            quo_c = {quo_c[hsva_pkg::QUO_W-2:0], 1'b1};
          end else begin
            quo_c = {quo_c[hsva_pkg::QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[st] <= rem_c;
        den_q[st] <= den_in;
        quo_q[st] <= quo_c;
      end
    end
  end

  assign quo = quo_q[hsva_pkg::DIV_STAGES-1];

endmodule

/* rtl/core/hsva_lane.sv */
// ----------------------------------------------------------------------------
// HSV to RGB channel lane
// Turns value, saturation and one hue ramp into one color channel over two
// register stages.
// ----------------------------------------------------------------------------
module hsva_lane (
  input  logic                               clk,
  input  logic                               ce,
  input  logic [hsva_pkg::CHANNEL_BITS-1:0]  v,
  input  logic [hsva_pkg::UNIT_W-1:0]        s,
  input  logic [hsva_pkg::UNIT_W-1:0]        n,
  output logic [hsva_pkg::CHANNEL_BITS-1:0]  col
);

  localparam int T_W = 2 * hsva_pkg::HUE_FRAC + 1;
  localparam int P_W = hsva_pkg::CHANNEL_BITS + hsva_pkg::UNIT_W;

  logic [T_W-1:0]                     t;
  logic [hsva_pkg::CHANNEL_BITS-1:0]  v_d;
  logic [T_W-1:0]                     w_full;
  logic [hsva_pkg::UNIT_W-1:0]        w;
  logic [P_W-1:0]                     p;
  logic [P_W:0]                       p_rnd;

  // Desaturation term s * (1 - n).
  always_ff @(posedge clk) begin
    if (ce) begin
      t   <= T_W'(s * (hsva_pkg::UNIT_ONE - n));
      v_d <= v;
    end
  end

  // Rounded weight, then scale by value.
  assign w_full = (T_W'(1) << (2 * hsva_pkg::HUE_FRAC)) - t
                + (T_W'(1) << (hsva_pkg::HUE_FRAC - 1));
  assign w      = w_full[T_W-1 -: hsva_pkg::UNIT_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      p <= P_W'(v_d * w);
    end
  end

  assign p_rnd = {1'b0, p} + ((P_W+1)'(1) << (hsva_pkg::HUE_FRAC - 1));
  assign col   = p_rnd[hsva_pkg::HUE_FRAC +: hsva_pkg::CHANNEL_BITS];

endmodule

/* rtl/core/hsv_hue_sat_val_adjust_top.sv */
// ----------------------------------------------------------------------------
// Hue / saturation / value adjust, top level
// Converts each RGBA pixel to HSV, rotates hue, scales saturation and value,
// converts back and blends with the input color. Alpha is copied through.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: red, green, blue, alpha (low bits first)
//   m_axis    out        tdata: red, green, blue, alpha (low bits first)
//   cfg       in         cfg_addr register index, cfg_data register value
//
// One pixel enters every clock while the pipeline is not stalled.
// The pipeline depth is set by the two hue/saturation dividers, four quotient bits a
// stage, followed by the gain, ramp, color and blend multiplier stages.
// The whole pipeline advances together; when the output register is full and
// not taken, every stage holds. Reset clears valid bits, sets config defaults.
// ----------------------------------------------------------------------------
module hsv_hue_sat_val_adjust_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hsva_pkg::TDATA_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [hsva_pkg::TDATA_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsva_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hsva_pkg::GAIN_W-1:0]       cfg_data
);

  localparam int CB = hsva_pkg::CHANNEL_BITS;
  localparam int UW = hsva_pkg::UNIT_W;
  localparam int RW = hsva_pkg::RAMP_W;
  localparam int GW = hsva_pkg::GAIN_W;
  localparam int DW = hsva_pkg::DIV_W;

  typedef struct packed {
    logic          pass;
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    logic [CB-1:0] a;
  } side_t;

  typedef struct packed {
    logic          gray;
    logic [CB-1:0] mx;
  } dside_t;

  // Configuration registers.
  logic [15:0]   hue_shift;
  logic [GW-1:0] sat_gain;
  logic [GW-1:0] val_gain;
  logic [GW-1:0] mix_factor;

  logic ce;
  logic vld  [hsva_pkg::PIPE_DEPTH];
  side_t side [hsva_pkg::PIPE_DEPTH];
  dside_t dside [hsva_pkg::DIV_STAGES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift  <= '0;
      sat_gain   <= hsva_pkg::GAIN_UNITY;
      val_gain   <= hsva_pkg::GAIN_UNITY;
      mix_factor <= hsva_pkg::MIX_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        hsva_pkg::CFG_HUE_SHIFT:  hue_shift  <= cfg_data[15:0];
        hsva_pkg::CFG_SAT_GAIN:   sat_gain   <= cfg_data;
        hsva_pkg::CFG_VAL_GAIN:   val_gain   <= cfg_data;
        hsva_pkg::CFG_MIX_FACTOR: mix_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output is full and stalled.
  assign ce            = !vld[hsva_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = ce;

  // Valid bits and sideband shift line.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < hsva_pkg::PIPE_DEPTH; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (ce) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < hsva_pkg::PIPE_DEPTH; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0].r    <= s_axis_tdata[0 +: CB];
      side[0].g    <= s_axis_tdata[CB +: CB];
      side[0].b    <= s_axis_tdata[2*CB +: CB];
      side[0].a    <= s_axis_tdata[3*CB +: CB];
      side[0].pass <= (mix_factor == '0) ||
                      (hue_shift == '0 && sat_gain == hsva_pkg::GAIN_UNITY &&
                       val_gain == hsva_pkg::GAIN_UNITY);
      for (int k = 1; k < hsva_pkg::PIPE_DEPTH; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Max, min, delta and hue sector numerator.
  logic [CB-1:0]          mx_c, mn_c, delta_c;
  logic signed [CB+3:0]   num_s;
  logic signed [CB+3:0]   r_s, g_s, b_s, d_s;
  logic [DW-1:0]          hue_num, hue_den, sat_num, sat_den;
  logic                   gray_q;
  logic [CB-1:0]          mx_q;

  always_comb begin
    mx_c = side[0].r;
    mn_c = side[0].r;
    if (side[0].g > mx_c) mx_c = side[0].g;
    if (side[0].b > mx_c) mx_c = side[0].b;
    if (side[0].g < mn_c) mn_c = side[0].g;
    if (side[0].b < mn_c) mn_c = side[0].b;
    delta_c = mx_c - mn_c;
    r_s = $signed({4'b0, side[0].r});
    g_s = $signed({4'b0, side[0].g});
    b_s = $signed({4'b0, side[0].b});
    d_s = $signed({4'b0, delta_c});
    priority if (mx_c == side[0].r) begin
      num_s = g_s - b_s;
    end else if (mx_c == side[0].g) begin
      num_s = (d_s <<< 1) + (b_s - r_s);
    end else begin
      num_s = (d_s <<< 2) + (r_s - g_s);
    end
    if (num_s < 0) begin
      num_s = num_s + (d_s <<< 2) + (d_s <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hue_num <= num_s[DW-1:0];
      hue_den <= (DW'(delta_c) << 2) + (DW'(delta_c) << 1);
      sat_num <= DW'(delta_c);
      sat_den <= DW'(mx_c);
      gray_q  <= (delta_c == '0);
      mx_q    <= mx_c;
    end
  end

  // Hue and saturation dividers, with gray flag and maximum alongside.
  logic [hsva_pkg::QUO_W-1:0] hue_quo, sat_quo;

  hsva_div u_hue_div (
    .clk (clk),
    .ce  (ce),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  hsva_div u_sat_div (
    .clk (clk),
    .ce  (ce),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      dside[0].gray <= gray_q;
      dside[0].mx   <= mx_q;
      for (int k = 1; k < hsva_pkg::DIV_STAGES; k++) begin
        dside[k] <= dside[k-1];
      end
    end
  end

  // Hue rotation and gain scaling with clamps.
  localparam int HF_W = hsva_pkg::HUE_FRAC;
  logic                 gray_d;
  logic [HF_W-1:0]      hue_c;
  logic [UW-1:0]        sat_c;
  logic [UW+GW-1:0]     sat_prod;
  logic [CB+GW-1:0]     val_prod;
  logic [HF_W-1:0]      hue_adj;
  logic [UW-1:0]        sat_adj;
  logic [CB-1:0]        val_adj;

  assign gray_d   = dside[hsva_pkg::DIV_STAGES-1].gray;
  assign hue_c    = gray_d ? '0 : hue_quo[HF_W-1:0];
  assign sat_c    = gray_d ? '0 : sat_quo;
  assign sat_prod = (UW+GW)'(sat_c * sat_gain) >> 15;
  assign val_prod = (CB+GW)'(dside[hsva_pkg::DIV_STAGES-1].mx * val_gain) >> 15;

  always_ff @(posedge clk) begin
    if (ce) begin
      hue_adj <= hue_c + {hue_shift, 8'b0};
      sat_adj <= (sat_prod > (UW+GW)'(hsva_pkg::UNIT_ONE)) ? hsva_pkg::UNIT_ONE
                                                           : sat_prod[UW-1:0];
      val_adj <= (val_prod > (CB+GW)'({CB{1'b1}})) ? {CB{1'b1}} : val_prod[CB-1:0];
    end
  end

  // Hue ramps for the three channels.
  logic signed [RW-1:0] h6, one_s;
  logic [UW-1:0]        nr, ng, nb;
  logic [UW-1:0]        sat_h;
  logic [CB-1:0]        val_h;

  assign h6    = $signed((RW'(hue_adj) << 2) + (RW'(hue_adj) << 1));
  assign one_s = $signed(RW'(hsva_pkg::UNIT_ONE));

  always_ff @(posedge clk) begin
    if (ce) begin
      nr    <= hsva_pkg::clamp_unit(hsva_pkg::abs_ramp(h6 - RW'(3) * one_s) - one_s);
      ng    <= hsva_pkg::clamp_unit(RW'(2) * one_s - hsva_pkg::abs_ramp(h6 - RW'(2) * one_s));
      nb    <= hsva_pkg::clamp_unit(RW'(2) * one_s - hsva_pkg::abs_ramp(h6 - RW'(4) * one_s));
      sat_h <= sat_adj;
      val_h <= val_adj;
    end
  end

  // Back to RGB, one lane per channel.
  logic [CB-1:0] col_r, col_g, col_b;

  hsva_lane u_lane_r (.clk(clk), .ce(ce), .v(val_h), .s(sat_h), .n(nr), .col(col_r));
  hsva_lane u_lane_g (.clk(clk), .ce(ce), .v(val_h), .s(sat_h), .n(ng), .col(col_g));
  hsva_lane u_lane_b (.clk(clk), .ce(ce), .v(val_h), .s(sat_h), .n(nb), .col(col_b));

  // Blend products against the original color.
  logic [GW-1:0]    f_sat, f_inv;
  logic [GW+CB-1:0] in_r, in_g, in_b, ad_r, ad_g, ad_b;

  assign f_sat = (mix_factor > hsva_pkg::MIX_ONE) ? hsva_pkg::MIX_ONE : mix_factor;
  assign f_inv = hsva_pkg::MIX_ONE - f_sat;

  always_ff @(posedge clk) begin
    if (ce) begin
      in_r <= (GW+CB)'(f_inv * side[hsva_pkg::IX_LANE].r);
      in_g <= (GW+CB)'(f_inv * side[hsva_pkg::IX_LANE].g);
      in_b <= (GW+CB)'(f_inv * side[hsva_pkg::IX_LANE].b);
      ad_r <= (GW+CB)'(f_sat * col_r);
      ad_g <= (GW+CB)'(f_sat * col_g);
      ad_b <= (GW+CB)'(f_sat * col_b);
    end
  end

  // Rounded blend sum and pass-through select into the output register.
  logic [GW+CB:0] sum_r, sum_g, sum_b;
  logic [CB-1:0]  out_r, out_g, out_b;

  assign sum_r = (GW+CB+1)'(in_r) + (GW+CB+1)'(ad_r) + (GW+CB+1)'(32768);
  assign sum_g = (GW+CB+1)'(in_g) + (GW+CB+1)'(ad_g) + (GW+CB+1)'(32768);
  assign sum_b = (GW+CB+1)'(in_b) + (GW+CB+1)'(ad_b) + (GW+CB+1)'(32768);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (side[hsva_pkg::IX_MIX].pass) begin
        out_r <= side[hsva_pkg::IX_MIX].r;
        out_g <= side[hsva_pkg::IX_MIX].g;
        out_b <= side[hsva_pkg::IX_MIX].b;
      end else begin
        out_r <= sum_r[16 +: CB];
        out_g <= sum_g[16 +: CB];
        out_b <= sum_b[16 +: CB];
      end
    end
  end

  assign m_axis_tvalid = vld[hsva_pkg::IX_OUT];
  assign m_axis_tdata  = hsva_pkg::TDATA_W'({side[hsva_pkg::IX_OUT].a, out_b, out_g, out_r});

endmodule
